FILE: src/ordered_dither_span_builder_assert.svh
// ----------------------------------------------------------------------------
// ordered_dither_span_builder assertion macros
// Concurrent assertion helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_SPAN_BUILDER_ASSERT_SVH
`define ORDERED_DITHER_SPAN_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define ODSB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define ODSB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ODSB_ASSERT(label, prop, msg)
`define ODSB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/odsb_pkg.sv
// ----------------------------------------------------------------------------
// odsb_pkg
// Types and constants shared by the ordered dither span builder.
// ----------------------------------------------------------------------------
package odsb_pkg;

	// configuration register indexes
	localparam logic [1:0] CfgDitherEnable = 2'd0;
	localparam logic [1:0] CfgInvertOutput = 2'd1;
	localparam logic [1:0] CfgOriginX      = 2'd2;
	localparam logic [1:0] CfgOriginY      = 2'd3;

	localparam int MaxWidth   = 4096;
	localparam int PlainLimit = 255 * 3 / 2;

	localparam logic [15:0] LumR        = 16'd77;
	localparam logic [15:0] LumG        = 16'd150;
	localparam logic [15:0] LumB        = 16'd29;
	localparam logic [8:0]  DitherBias  = 9'd8;

	localparam logic [3:0] BayerTab [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [11:0] col;
		logic [11:0] row;
		logic        row_end;
	} pix_t;

	typedef struct packed {
		logic signed [15:0] span_x_start;
		logic signed [15:0] span_x_end;
		logic signed [15:0] span_y;
		logic               pen;
		logic               last_of_run;
	} span_t;

	typedef struct packed {
		logic visible;
		logic pen;
	} pix_eval_t;

endpackage

FILE: src/odsb_pixel_eval.sv
// ----------------------------------------------------------------------------
// odsb_pixel_eval
// Bayer threshold, visibility test and one-bit pen for a single pixel.
// ----------------------------------------------------------------------------
module odsb_pixel_eval (
	input  odsb_pkg::pix_t      pix,
	input  logic                dither_enable,
	input  logic                invert_output,
	output odsb_pkg::pix_eval_t res
);
	import odsb_pkg::*;

	logic [7:0]  thresh;
	logic [15:0] lum_sum;
	logic [8:0]  lum_limit;
	logic [9:0]  rgb_sum;
	logic        white;

	always_comb begin
		thresh    = {BayerTab[{pix.row[1:0], pix.col[1:0]}], 4'b0000};
		lum_sum   = LumR * {8'd0, pix.red} + LumG * {8'd0, pix.green}
			+ LumB * {8'd0, pix.blue};
		lum_limit = {1'b0, thresh} + DitherBias;
		rgb_sum   = {2'b00, pix.red} + {2'b00, pix.green} + {2'b00, pix.blue};
		if (dither_enable) begin
			white = {1'b0, lum_sum[15:8]} >= lum_limit;
		end else begin
			white = rgb_sum > 10'(PlainLimit);
		end
		res.visible = (pix.alpha > thresh) && ({5'd0, pix.col} < 17'(MaxWidth));
		res.pen     = white ^ invert_output;
	end

endmodule

FILE: src/ordered_dither_span_builder.sv
// ----------------------------------------------------------------------------
// ordered_dither_span_builder
// Dithers (or, with dithering off, thresholds) an RGBA pixel stream to a one-bit pen and merges runs into spans.
// ----------------------------------------------------------------------------
// Registers: a span is presented once the transaction that closes it has passed
//   the input register, then the output register.
// Throughput: one pixel per cycle unless span_stall holds the output; a pixel
//   closing two spans holds the input register, as the output register takes one span.
// Reset: arst_n clears the open run, both valid flags and the configuration
//   registers (invert_output resets to 1, all others to 0).
`include "ordered_dither_span_builder_assert.svh"

module ordered_dither_span_builder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_wdata,
	input  logic            pix_valid,
	output logic            pix_stall,
	input  odsb_pkg::pix_t  pix,
	output logic            span_valid,
	input  logic            span_stall,
	output odsb_pkg::span_t span
);
	import odsb_pkg::*;

	logic        dither_enable_q;
	logic        invert_output_q;
	logic [15:0] origin_x_q;
	logic [15:0] origin_y_q;

	logic        pix_valid_s1;
	pix_t        pix_s1;

	logic        run_active_q;
	logic [11:0] run_start_q;
	logic [11:0] run_end_q;
	logic [11:0] run_row_q;
	logic        run_pen_q;
	logic        phase_q;

	logic        span_valid_q;
	span_t       span_q;

	pix_eval_t   ev;

	logic        extend;
	logic        emit_old;
	logic        start_new;
	logic        active_after;
	logic        emit_end;
	logic        need_out;
	logic        two_span;
	logic        out_free;
	logic        step;
	logic        consume;
	logic        nxt_active;
	logic [11:0] start_after;
	logic [11:0] row_after;
	logic        pen_after;
	logic [11:0] src_start;
	logic [11:0] src_end;
	logic [11:0] src_row;
	logic        src_pen;
	logic        src_last;
	span_t       span_nxt;

	odsb_pixel_eval u_eval (
		.pix           (pix_s1),
		.dither_enable (dither_enable_q),
		.invert_output (invert_output_q),
		.res           (ev)
	);

	always_comb begin
		extend = run_active_q && ev.visible && (pix_s1.row == run_row_q)
			&& ({1'b0, pix_s1.col} == ({1'b0, run_end_q} + 13'd1))
			&& (ev.pen == run_pen_q);
		emit_old     = run_active_q && !extend;
		start_new    = ev.visible && !extend;
		active_after = extend || start_new;
		emit_end     = pix_s1.row_end && active_after;
		start_after  = start_new ? pix_s1.col : run_start_q;
		row_after    = start_new ? pix_s1.row : run_row_q;
		pen_after    = start_new ? ev.pen : run_pen_q;

		if (phase_q) begin
			// second span of a pixel: the run it opened, closed by row end
			need_out  = 1'b1;
			two_span  = 1'b0;
			src_start = run_start_q;
			src_end   = run_end_q;
			src_row   = run_row_q;
			src_pen   = run_pen_q;
			src_last  = 1'b1;
			nxt_active = 1'b0;
		end else begin
			need_out = emit_old || emit_end;
			two_span = emit_old && emit_end;
			src_last = !two_span;
			if (emit_old) begin
				src_start = run_start_q;
				src_end   = run_end_q;
				src_row   = run_row_q;
				src_pen   = run_pen_q;
			end else begin
				src_start = start_after;
				src_end   = pix_s1.col;
				src_row   = row_after;
				src_pen   = pen_after;
			end
			nxt_active = two_span || (active_after && !emit_end);
		end

		out_free  = !span_valid_q || !span_stall;
		step      = pix_valid_s1 && (!need_out || out_free);
		consume   = step && !two_span;
		pix_stall = pix_valid_s1 && !consume;

		span_nxt.span_x_start = origin_x_q + {4'd0, src_start};
		span_nxt.span_x_end   = origin_x_q + {4'd0, src_end};
		span_nxt.span_y       = origin_y_q + {4'd0, src_row};
		span_nxt.pen          = src_pen;
		span_nxt.last_of_run  = src_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_enable_q <= 1'b0;
			invert_output_q <= 1'b1;
			origin_x_q      <= 16'd0;
			origin_y_q      <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgDitherEnable: dither_enable_q <= cfg_wdata[0];
				CfgInvertOutput: invert_output_q <= cfg_wdata[0];
				CfgOriginX:      origin_x_q      <= cfg_wdata;
				CfgOriginY:      origin_y_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
			span_valid_q <= 1'b0;
			run_active_q <= 1'b0;
			run_start_q  <= 12'd0;
			run_end_q    <= 12'd0;
			run_row_q    <= 12'd0;
			run_pen_q    <= 1'b0;
			phase_q      <= 1'b0;
		end else begin
			if (!pix_stall) begin
				pix_valid_s1 <= pix_valid;
			end
			if (out_free) begin
				span_valid_q <= step && need_out;
			end
			if (step) begin
				run_active_q <= nxt_active;
				phase_q      <= two_span;
				if (!phase_q) begin
					run_start_q <= start_after;
					run_end_q   <= pix_s1.col;
					run_row_q   <= row_after;
					run_pen_q   <= pen_after;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && !pix_stall) begin
			pix_s1 <= pix;
		end
		if (step && need_out) begin
			span_q <= span_nxt;
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

	`ODSB_ASSERT(a_phase_has_run, phase_q |-> (run_active_q && pix_valid_s1), "no open run")
	`ODSB_ASSERT(a_first_span_not_last, $rose(phase_q) |-> span_valid_q && !span_q.last_of_run, "early last")
	`ODSB_ASSERT_ALWAYS(a_stall_needs_item, pix_stall |-> pix_valid_s1, "stall while empty")

endmodule
